// ----- rtl/pwd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwd_pkg: shared types and constants for the packet word deframer
// Buffer size, derived widths, stream item types and drop codes.
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int BUF_BYTES  = 2048;
  localparam int WORD_BYTES = 4;
  localparam int WORD_SHIFT = $clog2(WORD_BYTES);

  localparam int DATA_W  = 32;
  localparam int EMPTY_W = 2;
  localparam int IDX_W   = 9;
  localparam int LEN_W   = 12;

  // byte count must hold the first value at or past BUF_BYTES
  localparam int CNT_W     = $clog2(BUF_BYTES + WORD_BYTES);
  localparam int IDX_EXT_W = (CNT_W > IDX_W + WORD_SHIFT) ? CNT_W : IDX_W + WORD_SHIFT;
  localparam int LEN_EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef enum logic [1:0] {
    DROP_NONE     = 2'd0,
    DROP_BROKEN   = 2'd1,
    DROP_TOO_LONG = 2'd2
  } drop_code_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_word;
    logic               start_mark;
    logic               end_mark;
    logic [EMPTY_W-1:0] empty_bytes;
  } in_t;

  typedef struct packed {
    logic              store_enable;
    logic [IDX_W-1:0]  store_index;
    logic [DATA_W-1:0] store_data;
    logic              deliver;
    logic [LEN_W-1:0]  deliver_length;
    drop_code_t        drop_code;
  } out_t;

endpackage

// ----- rtl/pwd_if.sv -----
// ----------------------------------------------------------------------------
// pwd_in_if / pwd_out_if: word and result request channels
// Valid/ready channels carrying the deframer input and result fields.
// ----------------------------------------------------------------------------
interface pwd_in_if;
  import pwd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_word;
  logic               start_mark;
  logic               end_mark;
  logic [EMPTY_W-1:0] empty_bytes;

  modport source (output valid, data_word, start_mark, end_mark, empty_bytes,
                  input ready);
  modport sink   (input valid, data_word, start_mark, end_mark, empty_bytes,
                  output ready);
endinterface

interface pwd_out_if;
  import pwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              store_enable;
  logic [IDX_W-1:0]  store_index;
  logic [DATA_W-1:0] store_data;
  logic              deliver;
  logic [LEN_W-1:0]  deliver_length;
  drop_code_t        drop_code;

  modport source (output valid, store_enable, store_index, store_data, deliver,
                  deliver_length, drop_code, input ready);
  modport sink   (input valid, store_enable, store_index, store_data, deliver,
                  deliver_length, drop_code, output ready);
endinterface

// ----- rtl/pwd_in_stage.sv -----
// ----------------------------------------------------------------------------
// pwd_in_stage: input register
// Captures one word request; refills in the same cycle it advances.
// ----------------------------------------------------------------------------
module pwd_in_stage (
  input  logic         clk,
  input  logic         rst,
  pwd_in_if.sink       words,
  input  logic         advance,
  output logic         hold_valid,
  output pwd_pkg::in_t hold_item
);
  import pwd_pkg::*;

  assign words.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (words.ready) begin
      hold_valid <= words.valid;
    end
    if (words.valid && words.ready) begin
      hold_item.data_word   <= words.data_word;
      hold_item.start_mark  <= words.start_mark;
      hold_item.end_mark    <= words.end_mark;
      hold_item.empty_bytes <= words.empty_bytes;
    end
  end

endmodule

// ----- rtl/pwd_core.sv -----
// ----------------------------------------------------------------------------
// pwd_core: framing state and per-word result logic
// Holds packet_open and byte_count; computes the result for the held word.
// ----------------------------------------------------------------------------
module pwd_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  pwd_pkg::in_t  item,
  output pwd_pkg::out_t result
);
  import pwd_pkg::*;

  logic             packet_open;
  logic [CNT_W-1:0] byte_count;
  logic             packet_open_next;
  logic [CNT_W-1:0] byte_count_next;

  logic                 open_eff;
  logic [CNT_W-1:0]     base;
  logic [CNT_W-1:0]     bumped;
  logic [IDX_EXT_W-1:0] base_ext;
  logic [LEN_EXT_W-1:0] len_ext;

  always_comb begin
    open_eff = item.start_mark || packet_open;
    base     = item.start_mark ? '0 : byte_count;
    bumped   = base + CNT_W'(WORD_BYTES);
    base_ext = IDX_EXT_W'(base);
    len_ext  = LEN_EXT_W'(bumped) - LEN_EXT_W'(item.empty_bytes);

    result           = '0;
    result.drop_code = (item.start_mark && packet_open) ? DROP_BROKEN : DROP_NONE;
    packet_open_next = open_eff;
    byte_count_next  = base;

    if (open_eff) begin
      result.store_enable = 1'b1;
      result.store_index  = base_ext[IDX_W+WORD_SHIFT-1:WORD_SHIFT];
      result.store_data   = item.data_word;
      byte_count_next     = bumped;
      if (item.end_mark) begin
        // end wins over a full buffer
        result.deliver        = 1'b1;
        result.deliver_length = len_ext[LEN_W-1:0];
        packet_open_next      = 1'b0;
        byte_count_next       = '0;
      end else if (bumped >= CNT_W'(BUF_BYTES)) begin
        result.drop_code = DROP_TOO_LONG;
        packet_open_next = 1'b0;
        byte_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      byte_count  <= '0;
    end else if (step) begin
      packet_open <= packet_open_next;
      byte_count  <= byte_count_next;
    end
  end

endmodule

// ----- rtl/pwd_out_stage.sv -----
// ----------------------------------------------------------------------------
// pwd_out_stage: result register
// Holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
module pwd_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  pwd_pkg::out_t result,
  output logic          can_load,
  pwd_out_if.source     results
);
  import pwd_pkg::*;

  out_t held;
  logic held_valid;

  assign can_load = !held_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (can_load) begin
      held_valid <= load;
    end
    if (load) begin
      held <= result;
    end
  end

  assign results.valid          = held_valid;
  assign results.store_enable   = held.store_enable;
  assign results.store_index    = held.store_index;
  assign results.store_data     = held.store_data;
  assign results.deliver        = held.deliver;
  assign results.deliver_length = held.deliver_length;
  assign results.drop_code      = held.drop_code;

endmodule

// ----- rtl/packet_word_deframer.sv -----
// ----------------------------------------------------------------------------
// packet_word_deframer: rebuild packets from marked 32-bit words
// Flow: an accepted word request is held in the input stage; its result is
//   registered in the output stage once the result side can take it.
// Throughput: one word per cycle while the result side is not stalled.
// Reset: synchronous rst clears both stage valids, packet_open and byte_count.
// ----------------------------------------------------------------------------
module packet_word_deframer (
  input  logic      clk,
  input  logic      rst,
  pwd_in_if.sink    words,
  pwd_out_if.source results
);
  import pwd_pkg::*;

  // Two registers frame the work: the input stage holds the word, the core
  // computes its one result from the framing state, and the output stage
  // holds that result. The word moves on (and the framing state advances)
  // only in the cycle the output stage can take the result, so a stall on
  // the result side backs up cleanly without losing or repeating a word.
  logic hold_valid;
  in_t  hold_item;
  out_t step_result;
  logic can_load;
  logic advance;

  // advance the held word when the result register is free or draining
  assign advance = hold_valid && can_load;

  pwd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .words      (words),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Start drops any open packet as broken and restarts the count at zero;
  // each word inside a packet is stored at byte_count / 4; end delivers the
  // length minus the empty bytes; reaching the buffer size without end
  // drops the packet as too long. Words outside a packet give an all-zero
  // result that still counts as one result request.
  pwd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .result (step_result)
  );

  pwd_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (step_result),
    .can_load (can_load),
    .results  (results)
  );

endmodule

// ----- rtl/pwd_checker.sv -----
// ----------------------------------------------------------------------------
// pwd_checker: port-level checks for the packet word deframer
// Watches the result channel and its reset behavior.
// ----------------------------------------------------------------------------
module pwd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  store_enable,
  input logic [pwd_pkg::IDX_W-1:0]  store_index,
  input logic [pwd_pkg::DATA_W-1:0] store_data,
  input logic                  deliver,
  input logic [pwd_pkg::LEN_W-1:0]  deliver_length,
  input logic [1:0]            drop_code
);
  import pwd_pkg::*;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(store_index)
      && $stable(store_data) && $stable(deliver_length) && $stable(drop_code))
    else $error("result changed while stalled");

  // nothing is offered after a reset cycle
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a delivered packet wrote its last word and was not dropped as too long
  a_deliver_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && deliver |-> store_enable && drop_code != DROP_TOO_LONG
      && deliver_length != '0)
    else $error("delivery without a stored final word");

  // a word outside a packet leaves every result field clear
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_enable |-> !deliver && drop_code == DROP_NONE
      && store_index == '0 && store_data == '0)
    else $error("result fields set without a store");

endmodule

bind packet_word_deframer pwd_checker u_pwd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .store_enable   (results.store_enable),
  .store_index    (results.store_index),
  .store_data     (results.store_data),
  .deliver        (results.deliver),
  .deliver_length (results.deliver_length),
  .drop_code      (results.drop_code)
);
